@@ rtl/line_signal_timer_sequencer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer: assertion macros
// Shared concurrent assertion forms for the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef LINE_SIGNAL_TIMER_SEQUENCER_UNIT_MACROS_SVH
`define LINE_SIGNAL_TIMER_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSTS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lsts_pkg.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer package
// Constants, codes, payload types and helpers shared by the sequencer files.
// ----------------------------------------------------------------------------
package lsts_pkg;

   localparam int CADENCE_DEPTH  = 16;
   localparam int CHUNK_SAMPLES  = 8;
   localparam int SAMPLES_PER_MS = 8;
   localparam int AFTERSTART_MS  = 100;
   localparam int AFTERKEWL_MS   = 300;
   localparam int RX_FLASH_MULT  = 8;

   localparam int TIMER_W    = 22;
   localparam int POS_W      = (CADENCE_DEPTH > 1) ? $clog2(CADENCE_DEPTH) : 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [3:0] state_type;
   typedef logic [1:0] signal_type;
   typedef logic [2:0] event_type;
   typedef logic [1:0] req_kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Transmit states. Loaded values above the last one are kept as they are.
   localparam state_type ST_ONHOOK     = 4'd0;
   localparam state_type ST_OFFHOOK    = 4'd1;
   localparam state_type ST_START      = 4'd2;
   localparam state_type ST_PREWINK    = 4'd3;
   localparam state_type ST_WINK       = 4'd4;
   localparam state_type ST_PREFLASH   = 4'd5;
   localparam state_type ST_FLASH      = 4'd6;
   localparam state_type ST_DEBOUNCE   = 4'd7;
   localparam state_type ST_AFTERSTART = 4'd8;
   localparam state_type ST_RINGON     = 4'd9;
   localparam state_type ST_RINGOFF    = 4'd10;
   localparam state_type ST_KEWL       = 4'd11;
   localparam state_type ST_AFTERKEWL  = 4'd12;

   localparam signal_type SIG_ONHOOK  = 2'd0;
   localparam signal_type SIG_OFFHOOK = 2'd1;
   localparam signal_type SIG_START   = 2'd2;

   localparam event_type EV_NONE         = 3'd0;
   localparam event_type EV_RINGERON     = 3'd1;
   localparam event_type EV_RINGEROFF    = 3'd2;
   localparam event_type EV_HOOKCOMPLETE = 3'd3;
   localparam event_type EV_ONHOOK       = 3'd4;

   localparam req_kind_type REQ_TICK    = 2'd0;
   localparam req_kind_type REQ_LOAD    = 2'd1;
   localparam req_kind_type REQ_CADENCE = 2'd2;

   localparam csr_index_type CSR_WINK_TIME       = 3'd0;
   localparam csr_index_type CSR_FLASH_TIME      = 3'd1;
   localparam csr_index_type CSR_RX_FLASH_TIME   = 3'd2;
   localparam csr_index_type CSR_ZONE_FIRST_CAD  = 3'd3;
   localparam csr_index_type CSR_ZONE_PAUSE      = 3'd4;
   localparam csr_index_type CSR_NONBLOCKING     = 3'd5;
   localparam csr_index_type CSR_KEWL_ONHOOK     = 3'd6;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        rx_onhook;
      logic [3:0]  new_state;
      logic [1:0]  new_signal;
      logic [19:0] new_timer;
      logic [3:0]  cadence_index;
      logic [15:0] cadence_value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  tx_state;
      logic [1:0]  tx_signal;
      logic [2:0]  event_res;
      logic        expired;
      logic        rx_timer_load;
      logic [18:0] rx_timer_value;
      logic [15:0] caller_id_timer;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
   } csr_payload_type;

   typedef struct packed {
      logic [15:0] wink_time_ms;
      logic [15:0] flash_time_ms;
      logic [15:0] rx_flash_time_ms;
      logic [15:0] zone_first_cadence_ms;
      logic [15:0] zone_pause;
      logic        nonblocking;
      logic        kewl_onhook;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      wink_time_ms:          16'd150,
      flash_time_ms:         16'd750,
      rx_flash_time_ms:      16'd1250,
      zone_first_cadence_ms: 16'd2000,
      zone_pause:            16'd0,
      nonblocking:           1'b0,
      kewl_onhook:           1'b0
   };

   // Duration in milliseconds to a timer load in samples.
   function automatic logic [TIMER_W-1:0] ms_to_samples(input logic [15:0] ms);
      logic [31:0] prod;
      prod = 32'(ms) * 32'(SAMPLES_PER_MS);
      return prod[TIMER_W-1:0];
   endfunction

endpackage

@@ rtl/lsts_if.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface lsts_req_if;
   import lsts_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lsts_rsp_if;
   import lsts_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lsts_csr_if;
   import lsts_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/line_signal_timer_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer unit
// Transmit hook-signalling sequencer for one phone line.
//
//   Channel  Direction  Carries
//   req_ch   in         tick, state/timer load or cadence entry write
//   rsp_ch   out        state, line signal, event and timer outputs
//   csr_ch   in         register index and write data
//
// Every request is handled in a single pass and one result is produced per
// request; a request can be taken in every cycle unless a result is stalled
// on rsp_ch. The result register frees up in the same cycle its transfer
// completes, so a stalled rsp_ch only holds off req_ch while a result is
// waiting. Reset is synchronous; the cadence table is cleared by it at once.
// Register writes are taken in every cycle outside reset.
// ----------------------------------------------------------------------------
module line_signal_timer_sequencer_unit (
   input logic        clock,
   input logic        reset,
   lsts_req_if.sink   req_ch,
   lsts_rsp_if.source rsp_ch,
   lsts_csr_if.sink   csr_ch
);
   import lsts_pkg::*;

   cfg_type         cfg;
   rsp_payload_type result;
   rsp_payload_type rsp_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            take;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign take         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   lsts_cfg_regs u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   lsts_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_ch.data),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

endmodule

@@ rtl/lsts_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer configuration registers
// Takes register writes and holds the timing and option settings.
// ----------------------------------------------------------------------------
module lsts_cfg_regs (
   input  logic             clock,
   input  logic             reset,
   lsts_csr_if.sink         csr_ch,
   output lsts_pkg::cfg_type cfg
);
   import lsts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = !reset;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.data.index)
            CSR_WINK_TIME:      cfg_in.wink_time_ms          = csr_ch.data.value;
            CSR_FLASH_TIME:     cfg_in.flash_time_ms         = csr_ch.data.value;
            CSR_RX_FLASH_TIME:  cfg_in.rx_flash_time_ms      = csr_ch.data.value;
            CSR_ZONE_FIRST_CAD: cfg_in.zone_first_cadence_ms = csr_ch.data.value;
            CSR_ZONE_PAUSE:     cfg_in.zone_pause            = csr_ch.data.value;
            CSR_NONBLOCKING:    cfg_in.nonblocking           = csr_ch.data.value[0];
            CSR_KEWL_ONHOOK:    cfg_in.kewl_onhook           = csr_ch.data.value[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/lsts_seq.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer core
// Holds the hook state, output timer and ring cadence, and works out the
// next state and the result of one request in a single pass.
// ----------------------------------------------------------------------------
module lsts_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  lsts_pkg::req_payload_type req,
   input  lsts_pkg::cfg_type        cfg,
   output lsts_pkg::rsp_payload_type result
);
   import lsts_pkg::*;

   state_type          state_ff, state_in;
   signal_type         signal_ff, signal_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        cid_ff, cid_in;
   logic [15:0]        cad_ff [CADENCE_DEPTH];

   logic [POS_W:0]     pos_inc;
   logic [POS_W-1:0]   pos_wrap;
   logic [15:0]        cad_entry;
   logic               cad_end;
   logic [POS_W-1:0]   cad_pos_next;
   logic [15:0]        cad_len;
   logic [POS_W+3:0]   widx;
   logic               cad_we;
   logic [31:0]        rx_prod;
   event_type          hook_ev;
   event_type          ev;
   logic               expired;
   logic               rx_load;

   // Step to the next cadence entry; an empty entry restarts at the zone default.
   always_comb begin
      pos_inc      = {1'b0, pos_ff} + (POS_W+1)'(1);
      pos_wrap     = (pos_inc >= (POS_W+1)'(CADENCE_DEPTH)) ? '0 : pos_inc[POS_W-1:0];
      cad_entry    = cad_ff[pos_wrap];
      cad_end      = (cad_entry == '0);
      cad_pos_next = cad_end ? '0 : pos_wrap;
      cad_len      = cad_end ? cfg.zone_first_cadence_ms : cad_entry;
   end

   assign rx_prod = 32'(cfg.rx_flash_time_ms) * 32'(RX_FLASH_MULT);
   assign hook_ev = cfg.nonblocking ? EV_HOOKCOMPLETE : EV_NONE;
   assign widx    = (POS_W+4)'(req.cadence_index);
   assign cad_we  = take && (req.req_type == REQ_CADENCE) &&
                    (widx < (POS_W+4)'(CADENCE_DEPTH));

   always_comb begin
      state_in  = state_ff;
      signal_in = signal_ff;
      timer_in  = timer_ff;
      pos_in    = pos_ff;
      cid_in    = cid_ff;
      ev        = EV_NONE;
      expired   = 1'b0;
      rx_load   = 1'b0;
      unique case (req.req_type)
         REQ_TICK: begin
            if (timer_ff != '0) begin
               if (timer_ff <= TIMER_W'(CHUNK_SAMPLES)) begin
                  expired  = 1'b1;
                  timer_in = '0;
                  unique case (state_ff)
                     ST_RINGOFF: begin
                        pos_in    = cad_pos_next;
                        signal_in = SIG_START;
                        state_in  = ST_RINGON;
                        timer_in  = ms_to_samples(cad_len);
                        ev        = EV_RINGERON;
                     end
                     ST_RINGON: begin
                        pos_in    = cad_pos_next;
                        cid_in    = cfg.zone_pause;
                        signal_in = SIG_OFFHOOK;
                        state_in  = ST_RINGOFF;
                        timer_in  = ms_to_samples(cad_len);
                        ev        = EV_RINGEROFF;
                     end
                     ST_START: begin
                        signal_in = SIG_OFFHOOK;
                        state_in  = ST_AFTERSTART;
                        timer_in  = ms_to_samples(16'(AFTERSTART_MS));
                     end
                     ST_PREWINK: begin
                        signal_in = SIG_OFFHOOK;
                        state_in  = ST_WINK;
                        timer_in  = ms_to_samples(cfg.wink_time_ms);
                     end
                     ST_WINK: begin
                        signal_in = SIG_ONHOOK;
                        state_in  = ST_ONHOOK;
                        ev        = hook_ev;
                     end
                     ST_PREFLASH: begin
                        signal_in = SIG_ONHOOK;
                        state_in  = ST_FLASH;
                        timer_in  = ms_to_samples(cfg.flash_time_ms);
                     end
                     ST_FLASH, ST_AFTERSTART: begin
                        signal_in = SIG_OFFHOOK;
                        state_in  = ST_OFFHOOK;
                        ev        = hook_ev;
                     end
                     ST_DEBOUNCE: begin
                        signal_in = SIG_OFFHOOK;
                        state_in  = ST_OFFHOOK;
                        rx_load   = req.rx_onhook;
                     end
                     ST_KEWL: begin
                        signal_in = SIG_ONHOOK;
                        state_in  = ST_AFTERKEWL;
                        timer_in  = ms_to_samples(16'(AFTERKEWL_MS));
                        ev        = hook_ev;
                     end
                     ST_AFTERKEWL: begin
                        state_in = ST_ONHOOK;
                        ev       = cfg.kewl_onhook ? EV_ONHOOK : EV_NONE;
                     end
                     default: begin
                        state_in = state_ff;
                     end
                  endcase
               end else begin
                  timer_in = timer_ff - TIMER_W'(CHUNK_SAMPLES);
               end
            end
         end
         REQ_LOAD: begin
            state_in  = req.new_state;
            signal_in = req.new_signal;
            timer_in  = TIMER_W'(req.new_timer);
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_comb begin
      result.tx_state        = state_in;
      result.tx_signal       = signal_in;
      result.event_res       = ev;
      result.expired         = expired;
      result.rx_timer_load   = rx_load;
      result.rx_timer_value  = rx_load ? rx_prod[18:0] : '0;
      result.caller_id_timer = cid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ONHOOK;
         signal_ff <= SIG_ONHOOK;
         timer_ff  <= '0;
         pos_ff    <= '0;
         cid_ff    <= '0;
      end else if (take) begin
         state_ff  <= state_in;
         signal_ff <= signal_in;
         timer_ff  <= timer_in;
         pos_ff    <= pos_in;
         cid_ff    <= cid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CADENCE_DEPTH; i++) begin
            cad_ff[i] <= '0;
         end
      end else if (cad_we) begin
         cad_ff[widx[POS_W-1:0]] <= req.cadence_value;
      end
   end

endmodule

@@ rtl/lsts_checker.sv @@
// ----------------------------------------------------------------------------
// Line signal timer sequencer checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "line_signal_timer_sequencer_unit_macros.svh"

module lsts_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lsts_pkg::rsp_payload_type rsp_data
);
   import lsts_pkg::*;

   `LSTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `LSTS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "stalled result changed")
   `LSTS_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid, "accepted request gave no result")
   `LSTS_ASSERT_SAME(a_rx_load, clock, reset, rsp_valid && rsp_data.rx_timer_load, rsp_data.expired && (rsp_data.tx_state == ST_OFFHOOK), "receive timer load outside debounce expiry")

endmodule

bind line_signal_timer_sequencer_unit lsts_checker u_lsts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
